@@ rtl/c3f_pkg.sv @@
// Shared types, constants and helpers of the 3x3 image filter.
package c3f_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned MAX_CH        = 3;
	localparam int unsigned HSPAN         = 2 * MAX_CH;
	localparam int unsigned QUEUE_DEPTH   = 4;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned IMG_W_W  = 11;
	localparam int unsigned IMG_H_W  = 16;
	localparam int unsigned CH_W     = 2;
	localparam int unsigned MODE_W   = 2;

	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_COLOR     = 3'd4;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// floor(x / 9) == (x * DIV9_RECIP) >> DIV9_SHIFT for every x below 2^21
	localparam int unsigned DIV9_SHIFT = 23;
	localparam logic [19:0] DIV9_RECIP = 20'd932068;

	typedef enum logic [MODE_W-1:0] {
		MODE_BLUR,
		MODE_LAPLACE,
		MODE_SHARPEN,
		MODE_PASS
	} mode_t;

	typedef struct packed {
		mode_t                filter_mode;
		logic [IMG_W_W-1:0]   image_width;
		logic [IMG_H_W-1:0]   image_height;
		logic [CH_W-1:0]      channel_count;
		logic [SAMPLE_W-1:0]  clip_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		filter_mode:   MODE_BLUR,
		image_width:   11'd640,
		image_height:  16'd480,
		channel_count: 2'd1,
		clip_max:      16'd255
	};

	typedef struct packed {
		logic [SAMPLE_W-1:0] val;
		logic                emit;
		logic                last;
		logic                top_ok;
		logic                bot_ok;
		logic                left_ok;
		logic                right_ok;
	} q_entry_t;

	function automatic int unsigned eff_width(logic [IMG_W_W-1:0] iw, int unsigned max_w);
		int unsigned w;
		w = 32'(iw);
		if (w == 0)
			w = 1;
		else if (w > max_w)
			w = max_w;
		return w;
	endfunction

	function automatic logic [IMG_H_W-1:0] eff_height(logic [IMG_H_W-1:0] h);
		return (h == '0) ? IMG_H_W'(1) : h;
	endfunction

	function automatic logic [CH_W-1:0] eff_chan(logic [CH_W-1:0] c);
		return (c == '0) ? CH_W'(1) : c;
	endfunction

	// samples in one interleaved image row
	function automatic int unsigned line_len(int unsigned w, logic [CH_W-1:0] ch);
		case (ch)
			2'd2: return w << 1;
			2'd3: return w + (w << 1);
			default: return w;
		endcase
	endfunction

endpackage

@@ rtl/c3f_front.sv @@
// Front end: accepts items, tracks the stream position and tags each beat for the back end.
module c3f_front #(
	parameter int unsigned MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  c3f_pkg::cfg_t                 cfg,
	input  logic                          restart,
	input  logic                          item_valid,
	input  logic                          cmd,
	input  logic [c3f_pkg::SAMPLE_W-1:0]  sample,
	output logic                          item_stall,
	input  logic                          q_full,
	output logic                          push,
	output c3f_pkg::q_entry_t             push_entry
);
	import c3f_pkg::*;

	localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned LAGW = $clog2((MAX_WIDTH + 1) * MAX_CH + 1);

	logic [WW-1:0]       w_eff;
	logic [IMG_H_W-1:0]  h_eff;
	logic [CH_W-1:0]     ch_eff;
	logic [LAGW-1:0]     lag;

	logic [CW-1:0]       col_q;
	logic [CH_W-1:0]     chan_q;
	logic [IMG_H_W-1:0]  row_q;
	logic [LAGW-1:0]     fill_q;
	logic                started_q;

	logic accept, drop, emit, chan_end, col_end, row_end;

	assign w_eff  = WW'(eff_width(cfg.image_width, MAX_WIDTH));
	assign h_eff  = eff_height(cfg.image_height);
	assign ch_eff = eff_chan(cfg.channel_count);
	assign lag    = LAGW'(line_len(32'(w_eff), ch_eff) + 32'(ch_eff));

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	// a flush with nothing of the image in flight is swallowed
	assign drop       = (cmd == CMD_FLUSH) && !started_q;
	assign push       = accept && !drop;
	assign emit       = fill_q >= lag;

	assign chan_end = chan_q == ch_eff - CH_W'(1);
	assign col_end  = WW'(col_q) == w_eff - WW'(1);
	assign row_end  = row_q == h_eff - IMG_H_W'(1);

	always_comb begin
		push_entry.val      = (cmd == CMD_SAMPLE) ? sample : '0;
		push_entry.emit     = emit;
		push_entry.last     = emit && chan_end && col_end && row_end;
		push_entry.top_ok   = row_q != '0;
		push_entry.bot_ok   = !row_end;
		push_entry.left_ok  = col_q != '0;
		push_entry.right_ok = !col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			chan_q    <= '0;
			row_q     <= '0;
			fill_q    <= '0;
			started_q <= 1'b0;
		end else if (restart) begin
			col_q     <= '0;
			chan_q    <= '0;
			row_q     <= '0;
			fill_q    <= '0;
			started_q <= 1'b0;
		end else if (push) begin
			if (emit) begin
				if (chan_end) begin
					chan_q <= '0;
					if (col_end) begin
						col_q <= '0;
						if (row_end) begin
							row_q     <= '0;
							fill_q    <= '0;
							started_q <= 1'b0;
						end else begin
							row_q <= row_q + IMG_H_W'(1);
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end else begin
					chan_q <= chan_q + CH_W'(1);
				end
			end else begin
				fill_q    <= fill_q + LAGW'(1);
				started_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/c3f_queue.sv @@
// Short FIFO between the front end and the back end.
module c3f_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  c3f_pkg::q_entry_t  push_entry,
	output logic               full,
	input  logic               pop,
	output logic               pop_valid,
	output c3f_pkg::q_entry_t  pop_entry
);
	import c3f_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	q_entry_t        ent_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full      = count_q == NW'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_entry = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + NW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - NW'(1);
		end
	end

endmodule

@@ rtl/c3f_back.sv @@
// Back end: line store, 3x3 window and the kernel arithmetic pipeline.
module c3f_back #(
	parameter int unsigned MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  c3f_pkg::cfg_t                 cfg,
	input  logic                          restart,
	input  logic                          q_valid,
	input  c3f_pkg::q_entry_t             q_entry,
	output logic                          pop,
	input  logic                          result_stall,
	output logic                          result_valid,
	output logic [c3f_pkg::SAMPLE_W-1:0]  filtered,
	output logic                          last
);
	import c3f_pkg::*;

	localparam int unsigned LDEPTH = MAX_CH * MAX_WIDTH;
	localparam int unsigned LW     = $clog2(LDEPTH);
	localparam int unsigned NTAP   = 9;
	localparam int unsigned RSUM_W = SAMPLE_W + 2;
	localparam int unsigned SUM_W  = SAMPLE_W + 4;
	localparam int unsigned KC_W   = SAMPLE_W + 3;
	localparam int unsigned LAP_W  = SAMPLE_W + 4;
	localparam int unsigned PROD_W = SUM_W + $bits(DIV9_RECIP);
	localparam int unsigned PRE_W  = LAP_W + 1;

	// line store: low half delays one row, high half two rows
	logic [2*SAMPLE_W-1:0] line_mem [LDEPTH];
	logic [2*SAMPLE_W-1:0] line_rd_q, byp_data_q, line_rd, line_wdata;
	logic                  byp_q;
	logic [LW-1:0]         ptr_q, ptr_nxt, lm1;
	logic [CH_W-1:0]       ch_eff;

	logic [SAMPLE_W-1:0] bot_q [1:HSPAN];
	logic [SAMPLE_W-1:0] mid_q [1:HSPAN];
	logic [SAMPLE_W-1:0] top_q [1:HSPAN];

	logic [SAMPLE_W-1:0] cur, l1, l2, b1, b2, m1, m2, t1, t2;
	logic [SAMPLE_W-1:0] tap [NTAP];
	logic                adv;

	logic                   v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic                   last_s1, last_s2, last_s3, last_s4, last_q;
	logic [SAMPLE_W-1:0]    tap_s1 [NTAP];
	logic [RSUM_W-1:0]      rsum_s2 [3];
	logic [RSUM_W-1:0]      cross_s2;
	logic [SAMPLE_W-1:0]    ctr_s2, ctr_s3, ctr_s4;
	logic [SUM_W-1:0]       sum9_s3;
	logic signed [LAP_W-1:0] lap_s3, lap_s4;
	logic [SAMPLE_W-1:0]    quot_s4;
	logic [SAMPLE_W-1:0]    filtered_q;

	logic [KC_W-1:0]        kc;
	logic [PROD_W-1:0]      prod;
	logic signed [PRE_W-1:0] pre;
	logic [SAMPLE_W-1:0]    clamped;

	assign ch_eff = eff_chan(cfg.channel_count);
	assign lm1    = LW'(line_len(eff_width(cfg.image_width, MAX_WIDTH), ch_eff) - 1);

	assign adv = !(out_valid_q && result_stall);
	assign pop = q_valid && adv;

	assign cur        = q_entry.val;
	assign line_rd    = byp_q ? byp_data_q : line_rd_q;
	assign l1         = line_rd[SAMPLE_W-1:0];
	assign l2         = line_rd[2*SAMPLE_W-1:SAMPLE_W];
	assign line_wdata = {l1, cur};

	always_comb begin
		if (restart)
			ptr_nxt = '0;
		else if (pop)
			ptr_nxt = (ptr_q == lm1) ? '0 : ptr_q + LW'(1);
		else
			ptr_nxt = ptr_q;
	end

	always_ff @(posedge clk) begin
		if (pop)
			line_mem[ptr_q] <= line_wdata;
		line_rd_q <= line_mem[ptr_nxt];
	end

	// one-sample rows read back the entry written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byp_q <= 1'b0;
		else
			byp_q <= pop && !restart && (ptr_nxt == ptr_q);
	end

	always_ff @(posedge clk) begin
		if (pop)
			byp_data_q <= line_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ptr_q <= '0;
		else
			ptr_q <= ptr_nxt;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bot_q[1] <= cur;
			mid_q[1] <= l1;
			top_q[1] <= l2;
			for (int k = 2; k <= HSPAN; k++) begin
				bot_q[k] <= bot_q[k-1];
				mid_q[k] <= mid_q[k-1];
				top_q[k] <= top_q[k-1];
			end
		end
	end

	// horizontal neighbors sit one and two pixels back in the interleaved stream
	always_comb begin
		case (ch_eff)
			2'd2: begin
				b1 = bot_q[2]; b2 = bot_q[4];
				m1 = mid_q[2]; m2 = mid_q[4];
				t1 = top_q[2]; t2 = top_q[4];
			end
			2'd3: begin
				b1 = bot_q[3]; b2 = bot_q[6];
				m1 = mid_q[3]; m2 = mid_q[6];
				t1 = top_q[3]; t2 = top_q[6];
			end
			default: begin
				b1 = bot_q[1]; b2 = bot_q[2];
				m1 = mid_q[1]; m2 = mid_q[2];
				t1 = top_q[1]; t2 = top_q[2];
			end
		endcase
		tap[0] = (q_entry.top_ok && q_entry.left_ok)  ? t2 : '0;
		tap[1] =  q_entry.top_ok                      ? t1 : '0;
		tap[2] = (q_entry.top_ok && q_entry.right_ok) ? l2 : '0;
		tap[3] =  q_entry.left_ok                     ? m2 : '0;
		tap[4] =  m1;
		tap[5] =  q_entry.right_ok                    ? l1 : '0;
		tap[6] = (q_entry.bot_ok && q_entry.left_ok)  ? b2 : '0;
		tap[7] =  q_entry.bot_ok                      ? b1 : '0;
		tap[8] = (q_entry.bot_ok && q_entry.right_ok) ? cur : '0;
	end

	always_comb begin
		if (cfg.filter_mode == MODE_SHARPEN)
			kc = KC_W'({ctr_s2, 2'b00}) + KC_W'(ctr_s2);
		else
			kc = KC_W'({ctr_s2, 2'b00});
	end

	assign prod = PROD_W'(sum9_s3) * PROD_W'(DIV9_RECIP);

	always_comb begin
		case (cfg.filter_mode) inside
			MODE_BLUR:                  pre = $signed(PRE_W'(quot_s4));
			MODE_LAPLACE, MODE_SHARPEN: pre = {lap_s4[LAP_W-1], lap_s4};
			default:                    pre = $signed(PRE_W'(ctr_s4));
		endcase
		if (pre < 0)
			clamped = '0;
		else if (pre > $signed(PRE_W'(cfg.clip_max)))
			clamped = cfg.clip_max;
		else
			clamped = pre[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop && q_entry.emit;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tap_s1   <= tap;
			last_s1  <= q_entry.last;

			rsum_s2[0] <= RSUM_W'(tap_s1[0]) + RSUM_W'(tap_s1[1]) + RSUM_W'(tap_s1[2]);
			rsum_s2[1] <= RSUM_W'(tap_s1[3]) + RSUM_W'(tap_s1[4]) + RSUM_W'(tap_s1[5]);
			rsum_s2[2] <= RSUM_W'(tap_s1[6]) + RSUM_W'(tap_s1[7]) + RSUM_W'(tap_s1[8]);
			cross_s2   <= RSUM_W'(tap_s1[1]) + RSUM_W'(tap_s1[3]) +
				RSUM_W'(tap_s1[5]) + RSUM_W'(tap_s1[7]);
			ctr_s2     <= tap_s1[4];
			last_s2    <= last_s1;

			sum9_s3 <= SUM_W'(rsum_s2[0]) + SUM_W'(rsum_s2[1]) + SUM_W'(rsum_s2[2]);
			lap_s3  <= $signed(LAP_W'(kc)) - $signed(LAP_W'(cross_s2));
			ctr_s3  <= ctr_s2;
			last_s3 <= last_s2;

			quot_s4 <= prod[DIV9_SHIFT +: SAMPLE_W];
			lap_s4  <= lap_s3;
			ctr_s4  <= ctr_s3;
			last_s4 <= last_s3;

			filtered_q <= clamped;
			last_q     <= last_s4;
		end
	end

	assign result_valid = out_valid_q;
	assign filtered     = filtered_q;
	assign last         = last_q;

endmodule

@@ rtl/conv3x3_image_filter.sv @@
// Top level of the streaming 3x3 image filter: register port, front end, queue, back end.
// Throughput: one beat per clock on the item side while the result side keeps up.
// Path: the beat that completes a window passes the queue and the five-stage kernel; that beat
// comes (width+1)*channels beats after the window's own sample.
// Reset: registers return to their defaults and the stream position clears; the line store
// is not cleared, rows above the top edge are masked instead, so no clearing pass is needed.
module conv3x3_image_filter #(
	parameter int unsigned MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [c3f_pkg::PADDR_W-1:0]   paddr,
	input  logic [c3f_pkg::PDATA_W-1:0]   pwdata,
	output logic [c3f_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,

	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          cmd,
	input  logic [c3f_pkg::SAMPLE_W-1:0]  sample,

	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [c3f_pkg::SAMPLE_W-1:0]  filtered,
	output logic                          last
);
	import c3f_pkg::*;

	localparam int unsigned IDX_LSB = 2;

	cfg_t                  cfg_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  cfg_write;
	logic                  restart;

	logic      push, q_full, pop, q_valid;
	q_entry_t  push_entry, q_entry;

	// Register port: zero wait states, one word per register.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[PADDR_W-1:IDX_LSB];
	assign cfg_write = psel && penable && pwrite && pready;

	// Any geometry write restarts the stream position in both halves; the
	// back end also rewinds its line pointer since the row length may change.
	assign restart = cfg_write && (reg_idx == REG_IMAGE_WIDTH ||
		reg_idx == REG_IMAGE_HEIGHT || reg_idx == REG_CHANNEL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_FILTER_MODE:   cfg_q.filter_mode   <= mode_t'(pwdata[MODE_W-1:0]);
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= pwdata[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= pwdata[IMG_H_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[CH_W-1:0];
				REG_MAX_COLOR:     cfg_q.clip_max      <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FILTER_MODE:   prdata = PDATA_W'(cfg_q.filter_mode);
			REG_IMAGE_WIDTH:   prdata = PDATA_W'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:  prdata = PDATA_W'(cfg_q.image_height);
			REG_CHANNEL_COUNT: prdata = PDATA_W'(cfg_q.channel_count);
			REG_MAX_COLOR:     prdata = PDATA_W'(cfg_q.clip_max);
			default:           prdata = '0;
		endcase
	end

	// Front end: swallow idle flushes, count the stream position, mark which
	// beats complete a window and which window sits on an image edge.
	c3f_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.restart    (restart),
		.item_valid (item_valid),
		.cmd        (cmd),
		.sample     (sample),
		.item_stall (item_stall),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue: lets the item side keep flowing, until it fills, while a result waits to be taken.
	c3f_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry)
	);

	// Back end: advance the line store and window on every popped beat, run
	// the kernel and clamp, and hold the result until the output side takes it.
	c3f_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.restart      (restart),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.pop          (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.filtered     (filtered),
		.last         (last)
	);

endmodule
